FILE: rtl/ips_pkg.sv
`default_nettype none
// ============================================================================
// ips_pkg
// Shared types and constants for the incremental saturating PID unit.
// ============================================================================
package ips_pkg;

    // Register map: word index taken from paddr[4:2].
    typedef enum logic [2:0] {
        REG_PROP_GAIN   = 3'd0,
        REG_INTEG_GAIN  = 3'd1,
        REG_DERIV_GAIN  = 3'd2,
        REG_INTEG_LIMIT = 3'd3,
        REG_STEP_LIMIT  = 3'd4
    } t_reg_idx;

    localparam int IN_W    = 16;   // target and measured
    localparam int ERR_W   = 17;   // target - measured
    localparam int TP_W    = 18;   // first difference
    localparam int TI_W    = 17;   // clamped error
    localparam int TD_W    = 19;   // second difference
    localparam int GAIN_W  = 16;
    localparam int SUM_W   = 36;   // weighted sum of the three products
    localparam int STEP_W  = 25;   // step after its clamp
    localparam int ACC_W   = 24;   // accumulator, Q15.8

    // Accumulator saturation level, 32767.0 in Q15.8.
    localparam logic signed [ACC_W-1:0] ACC_LIMIT = 24'sd8388352;

    localparam int MID_DEPTH_DEF = 4;
    localparam int OUT_DEPTH_DEF = 4;

    // Difference terms handed from the front to the back.
    typedef struct packed {
        logic signed [TP_W-1:0] tp;
        logic signed [TI_W-1:0] ti;
        logic signed [TD_W-1:0] td;
    } t_terms;

endpackage
`default_nettype wire

FILE: rtl/ips_queue.sv
`default_nettype none
// ============================================================================
// ips_queue
// Small first-word-fall-through queue with full and empty flags.
// ============================================================================
module ips_queue
    import ips_pkg::*;
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_wr,
    input  wire logic [WIDTH-1:0] i_wdata,
    output logic                  o_full,
    input  wire logic             i_rd,
    output logic [WIDTH-1:0]      o_rdata,
    output logic                  o_empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wr_ptr, n_wr_ptr;
    logic [AW-1:0]    r_rd_ptr, n_rd_ptr;
    logic [CW-1:0]    r_count,  n_count;
    logic             w_wr_en, w_rd_en;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign w_wr_en = i_wr && !o_full;
    assign w_rd_en = i_rd && !o_empty;
    assign o_rdata = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        if (w_wr_en) begin
            n_wr_ptr = (r_wr_ptr == AW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (w_rd_en) begin
            n_rd_ptr = (r_rd_ptr == AW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        unique case ({w_wr_en, w_rd_en})
            2'b10:   n_count = r_count + 1'b1;
            2'b01:   n_count = r_count - 1'b1;
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_mem[r_wr_ptr] <= i_wdata;
        end
    end

endmodule
`default_nettype wire

FILE: rtl/ips_front.sv
`default_nettype none
// ============================================================================
// ips_front
// Forms the error of each accepted word and its difference terms, and keeps
// the two previous errors.
// ============================================================================
module ips_front
    import ips_pkg::*;
(
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_accept,
    input  wire logic signed [IN_W-1:0]   i_target,
    input  wire logic signed [IN_W-1:0]   i_measured,
    input  wire logic [IN_W-1:0]          i_integ_term_limit,
    output t_terms                        o_terms
);

    logic signed [ERR_W-1:0] r_err_prev,  n_err_prev;
    logic signed [ERR_W-1:0] r_err_prev2, n_err_prev2;
    logic signed [ERR_W-1:0] w_err;
    logic signed [TP_W-1:0]  w_err_x, w_lim, w_nlim, w_ti_x;

    assign w_err   = ERR_W'(i_target) - ERR_W'(i_measured);
    assign w_err_x = TP_W'(w_err);
    assign w_lim   = $signed({2'b00, i_integ_term_limit});
    assign w_nlim  = -w_lim;

    always_comb begin
        if (w_err_x > w_lim) begin
            w_ti_x = w_lim;
        end else if (w_err_x < w_nlim) begin
            w_ti_x = w_nlim;
        end else begin
            w_ti_x = w_err_x;
        end
    end

    assign o_terms.tp = TP_W'(w_err) - TP_W'(r_err_prev);
    assign o_terms.ti = TI_W'(w_ti_x);
    assign o_terms.td = TD_W'(w_err) - (TD_W'(r_err_prev) <<< 1) + TD_W'(r_err_prev2);

    always_comb begin
        n_err_prev  = r_err_prev;
        n_err_prev2 = r_err_prev2;
        if (i_accept) begin
            n_err_prev  = w_err;
            n_err_prev2 = r_err_prev;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_err_prev  <= '0;
            r_err_prev2 <= '0;
        end else begin
            r_err_prev  <= n_err_prev;
            r_err_prev2 <= n_err_prev2;
        end
    end

endmodule
`default_nettype wire

FILE: rtl/ips_back.sv
`default_nettype none
// ============================================================================
// ips_back
// Three-stage pipeline: gain products, clamped step, saturating accumulator.
// ============================================================================
module ips_back
    import ips_pkg::*;
(
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic signed [GAIN_W-1:0] i_prop_gain,
    input  wire logic signed [GAIN_W-1:0] i_integ_gain,
    input  wire logic signed [GAIN_W-1:0] i_deriv_gain,
    input  wire logic [IN_W-1:0]          i_step_limit,
    input  wire t_terms                   i_terms,
    input  wire logic                     i_terms_valid,
    output logic                          o_terms_pop,
    input  wire logic                     i_out_full,
    output logic                          o_out_wr,
    output logic signed [ACC_W-1:0]       o_out_data
);

    localparam int PP_W = GAIN_W + TP_W;
    localparam int PI_W = GAIN_W + TI_W;
    localparam int PD_W = GAIN_W + TD_W;

    logic                     w_adv;
    logic                     r_v1, r_v2;
    logic signed [PP_W-1:0]   r_pp;
    logic signed [PI_W-1:0]   r_pi;
    logic signed [PD_W-1:0]   r_pd;
    logic signed [STEP_W-1:0] r_step;
    logic signed [ACC_W-1:0]  r_accum, n_accum;
    logic signed [SUM_W-1:0]  w_sum, w_slim, w_snlim, w_step_x;
    logic signed [ACC_W+1:0]  w_acc_sum, w_alim;

    // The whole pipeline moves together whenever the result queue has room.
    assign w_adv       = !i_out_full;
    assign o_terms_pop = w_adv && i_terms_valid;

    assign w_sum   = SUM_W'(r_pp) + SUM_W'(r_pi) + SUM_W'(r_pd);
    assign w_slim  = $signed({12'd0, i_step_limit, 8'd0});
    assign w_snlim = -w_slim;

    always_comb begin
        if (w_sum > w_slim) begin
            w_step_x = w_slim;
        end else if (w_sum < w_snlim) begin
            w_step_x = w_snlim;
        end else begin
            w_step_x = w_sum;
        end
    end

    assign w_acc_sum = (ACC_W + 2)'(r_accum) + (ACC_W + 2)'(r_step);
    assign w_alim    = (ACC_W + 2)'(ACC_LIMIT);

    always_comb begin
        if (w_acc_sum > w_alim) begin
            n_accum = ACC_LIMIT;
        end else if (w_acc_sum < -w_alim) begin
            n_accum = -ACC_LIMIT;
        end else begin
            n_accum = ACC_W'(w_acc_sum);
        end
    end

    assign o_out_wr   = w_adv && r_v2;
    assign o_out_data = n_accum;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1    <= 1'b0;
            r_v2    <= 1'b0;
            r_accum <= '0;
        end else if (w_adv) begin
            r_v1 <= i_terms_valid;
            r_v2 <= r_v1;
            if (r_v2) begin
                r_accum <= n_accum;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_pp   <= i_prop_gain  * $signed(i_terms.tp);
            r_pi   <= i_integ_gain * $signed(i_terms.ti);
            r_pd   <= i_deriv_gain * $signed(i_terms.td);
            r_step <= STEP_W'(w_step_x);
        end
    end

endmodule
`default_nettype wire

FILE: rtl/incremental_pid_saturating_unit.sv
`default_nettype none
// Path: term queue, product stage, step stage, then the accumulator write
// into the result queue. Throughput: one word per cycle while the result
// queue has room; the accumulator register feeds back into its own update.
// Reset: synchronous, active low; clears registers, error history,
// accumulator and both queues. There is no clearing pass.
// ============================================================================
// incremental_pid_saturating_unit
// Velocity-form PID with clamped integral term, clamped step and a saturating
// Q15.8 accumulator, behind queue-style push/pop ports and an APB-style port.
// ============================================================================
module incremental_pid_saturating_unit
    import ips_pkg::*;
#(
    parameter int MID_DEPTH = MID_DEPTH_DEF,
    parameter int OUT_DEPTH = OUT_DEPTH_DEF
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    // Sample side
    input  wire logic                    push,
    output logic                         full,
    input  wire logic signed [IN_W-1:0]  i_target,
    input  wire logic signed [IN_W-1:0]  i_measured,
    // Result side
    output logic                         empty,
    input  wire logic                    pop,
    output logic signed [ACC_W-1:0]      o_control_out,
    // Register port
    input  wire logic                    psel,
    input  wire logic                    penable,
    input  wire logic                    pwrite,
    input  wire logic [4:0]              paddr,
    input  wire logic [31:0]             pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready
);

    // ------------------------------------------------------------------
    // Configuration registers. Writes land on the access phase; addresses
    // past the last register are ignored. Reads return the raw 16 bits.
    // ------------------------------------------------------------------
    logic signed [GAIN_W-1:0] r_prop_gain, r_integ_gain, r_deriv_gain;
    logic [IN_W-1:0]          r_integ_limit, r_step_limit;
    logic                     w_cfg_wr;
    t_reg_idx                 w_reg_idx;

    assign pready    = 1'b1;
    assign w_cfg_wr  = psel && penable && pwrite && pready;
    assign w_reg_idx = t_reg_idx'(paddr[4:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prop_gain   <= '0;
            r_integ_gain  <= '0;
            r_deriv_gain  <= '0;
            r_integ_limit <= '0;
            r_step_limit  <= '0;
        end else if (w_cfg_wr) begin
            unique case (w_reg_idx)
                REG_PROP_GAIN:   r_prop_gain   <= pwdata[15:0];
                REG_INTEG_GAIN:  r_integ_gain  <= pwdata[15:0];
                REG_DERIV_GAIN:  r_deriv_gain  <= pwdata[15:0];
                REG_INTEG_LIMIT: r_integ_limit <= pwdata[15:0];
                REG_STEP_LIMIT:  r_step_limit  <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (w_reg_idx)
            REG_PROP_GAIN:   prdata = {16'd0, r_prop_gain};
            REG_INTEG_GAIN:  prdata = {16'd0, r_integ_gain};
            REG_DERIV_GAIN:  prdata = {16'd0, r_deriv_gain};
            REG_INTEG_LIMIT: prdata = {16'd0, r_integ_limit};
            REG_STEP_LIMIT:  prdata = {16'd0, r_step_limit};
            default:         prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Front: every accepted word immediately yields its difference terms,
    // and the error history moves on. The terms wait in a short queue, so
    // the front keeps accepting while the back is stalled by the result
    // side, until that queue fills.
    // ------------------------------------------------------------------
    logic   w_accept;
    logic   w_mid_full, w_mid_empty, w_mid_pop;
    t_terms w_front_terms, w_mid_terms;

    assign full     = w_mid_full;
    assign w_accept = push && !w_mid_full;

    ips_front u_front (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_accept           (w_accept),
        .i_target           (i_target),
        .i_measured         (i_measured),
        .i_integ_term_limit (r_integ_limit),
        .o_terms            (w_front_terms)
    );

    ips_queue #(
        .WIDTH ($bits(t_terms)),
        .DEPTH (MID_DEPTH)
    ) u_mid_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (w_accept),
        .i_wdata (w_front_terms),
        .o_full  (w_mid_full),
        .i_rd    (w_mid_pop),
        .o_rdata (w_mid_terms),
        .o_empty (w_mid_empty)
    );

    // ------------------------------------------------------------------
    // Back: products, clamped step and the saturating accumulator. It
    // advances whenever the result queue has room, and writes each new
    // accumulator value into that queue.
    // ------------------------------------------------------------------
    logic                    w_out_full, w_out_wr;
    logic signed [ACC_W-1:0] w_out_data;

    ips_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_prop_gain   (r_prop_gain),
        .i_integ_gain  (r_integ_gain),
        .i_deriv_gain  (r_deriv_gain),
        .i_step_limit  (r_step_limit),
        .i_terms       (w_mid_terms),
        .i_terms_valid (!w_mid_empty),
        .o_terms_pop   (w_mid_pop),
        .i_out_full    (w_out_full),
        .o_out_wr      (w_out_wr),
        .o_out_data    (w_out_data)
    );

    // The result queue holds finished words until the consumer pops them.
    ips_queue #(
        .WIDTH (ACC_W),
        .DEPTH (OUT_DEPTH)
    ) u_out_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (w_out_wr),
        .i_wdata (w_out_data),
        .o_full  (w_out_full),
        .i_rd    (pop),
        .o_rdata (o_control_out),
        .o_empty (empty)
    );

`ifndef SYNTH
    // The back never writes a word that the result queue would drop.
    a_no_out_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_out_wr |-> !w_out_full)
        else $error("result queue written while full");

    // The back only takes terms that are present.
    a_no_mid_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_mid_pop |-> !w_mid_empty)
        else $error("term queue read while empty");

    // Every result stays inside the saturation band.
    a_out_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> (o_control_out <= ACC_LIMIT) && (o_control_out >= -ACC_LIMIT))
        else $error("result outside saturation band");

    // Reset leaves no result waiting.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> empty)
        else $error("result pending after reset");
`endif

endmodule
`default_nettype wire

FILE: verif/tb_incremental_pid_saturating_unit.sv
// ============================================================================
// tb_incremental_pid_saturating_unit
// Self-checking bench for the velocity-form PID unit. A directed table covers
// reset behavior, gain and limit extremes, the clamps and saturation. Random
// phases then reload the registers over the APB-style port and stream samples.
// Each result word is checked against a typed value or the in-bench PID model.
// ============================================================================
module tb_incremental_pid_saturating_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import ips_pkg::*;

    localparam int LATENCY       = 3;
    localparam int RESET_CYCLES  = 9;
    localparam int NUM_PHASES    = 10;
    localparam int PHASE_ITEMS   = 153;
    // The receiver stalls this long once, so the block backs up and raises full.
    localparam int HOLD_CYCLES   = 400;
    // Longest quiet spell of a correct run is the long hold above plus a
    // register reload; this limit is several times that.
    localparam int STALL_LIMIT   = 2500;
    localparam int PLAN_LEN      = 27;

    typedef enum logic {
        ROW_SETTINGS,
        ROW_SAMPLE
    } t_row_kind;

    // One row of the directed plan. For a settings row w0..w4 are prop gain,
    // integral gain, derivative gain, integral limit and step limit. For a
    // sample row w0 is the target and w1 the measured value; when typed is
    // set, want is the result written in by hand.
    typedef struct packed {
        t_row_kind   kind;
        logic [15:0] w0;
        logic [15:0] w1;
        logic [15:0] w2;
        logic [15:0] w3;
        logic [15:0] w4;
        logic        typed;
        logic [23:0] want;
    } t_row;

    typedef enum int {
        MODE_TAME,
        MODE_WILD,
        MODE_CORNER,
        MODE_MIXED
    } t_mode;

    logic                     i_clk;
    logic                     i_rst_n;
    logic                     push;
    wire logic                full;
    logic signed [IN_W-1:0]   i_target;
    logic signed [IN_W-1:0]   i_measured;
    wire logic                empty;
    logic                     pop;
    wire logic signed [ACC_W-1:0] o_control_out;
    logic                     psel;
    logic                     penable;
    logic                     pwrite;
    logic [4:0]               paddr;
    logic [31:0]              pwdata;
    wire logic [31:0]         prdata;
    wire logic                pready;

    // Model state: register copies, error history and the Q15.8 accumulator.
    logic [15:0]              reg_shadow [5];
    logic signed [17:0]       err_d1;
    logic signed [17:0]       err_d2;
    logic signed [24:0]       drive_acc;

    // Result words still owed by the block, oldest first.
    logic [23:0]              drive_q [$];

    int                       err_cnt;
    // Traffic controls shared by the two sides.
    logic                     no_idle;
    logic                     hold_req;
    logic                     hold_done;

    t_row                     plan [PLAN_LEN];

    incremental_pid_saturating_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .push          (push),
        .full          (full),
        .i_target      (i_target),
        .i_measured    (i_measured),
        .empty         (empty),
        .pop           (pop),
        .o_control_out (o_control_out),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------------
    // Controller model
    // ------------------------------------------------------------------------
    function automatic longint clip_sym(input longint v, input longint lim);
        if (v > lim) return lim;
        if (v < -lim) return -lim;
        return v;
    endfunction

    // Takes one sample, moves the model state on and returns the new output.
    function automatic logic [23:0] advance_pid(input logic [15:0] tgt,
                                                input logic [15:0] meas);
        longint err;
        longint prop_t;
        longint integ_t;
        longint deriv_t;
        longint step;
        err     = longint'($signed(tgt)) - longint'($signed(meas));
        prop_t  = err - longint'(err_d1);
        integ_t = clip_sym(err, longint'(reg_shadow[REG_INTEG_LIMIT]));
        deriv_t = err - 2 * longint'(err_d1) + longint'(err_d2);
        // Gains are Q8.8, so the weighted sum already carries 8 fraction bits.
        step = longint'($signed(reg_shadow[REG_PROP_GAIN])) * prop_t
             + longint'($signed(reg_shadow[REG_INTEG_GAIN])) * integ_t
             + longint'($signed(reg_shadow[REG_DERIV_GAIN])) * deriv_t;
        step = clip_sym(step, longint'(reg_shadow[REG_STEP_LIMIT]) * 256);
        err_d2    = err_d1;
        err_d1    = err[17:0];
        drive_acc = 25'(clip_sym(longint'(drive_acc) + step, longint'(ACC_LIMIT)));
        return drive_acc[23:0];
    endfunction

    // ------------------------------------------------------------------------
    // Directed plan helpers
    // ------------------------------------------------------------------------
    function automatic t_row row_set(input logic [15:0] kp, input logic [15:0] ki,
                                     input logic [15:0] kd, input logic [15:0] il,
                                     input logic [15:0] sl);
        t_row r;
        r      = '0;
        r.kind = ROW_SETTINGS;
        r.w0   = kp;
        r.w1   = ki;
        r.w2   = kd;
        r.w3   = il;
        r.w4   = sl;
        return r;
    endfunction

    function automatic t_row row_smp(input logic [15:0] tgt, input logic [15:0] meas);
        t_row r;
        r      = '0;
        r.kind = ROW_SAMPLE;
        r.w0   = tgt;
        r.w1   = meas;
        return r;
    endfunction

    function automatic t_row row_fix(input logic [15:0] tgt, input logic [15:0] meas,
                                     input logic [23:0] want);
        t_row r;
        r       = row_smp(tgt, meas);
        r.typed = 1'b1;
        r.want  = want;
        return r;
    endfunction

    function automatic logic [15:0] sat16(input int v);
        if (v > 32767) return 16'h7FFF;
        if (v < -32768) return 16'h8000;
        return v[15:0];
    endfunction

    function automatic logic [15:0] corner_word();
        case ($urandom_range(0, 4))
            0: return 16'h0000;
            1: return 16'h0001;
            2: return 16'h7FFF;
            3: return 16'h8000;
            default: return 16'hFFFF;
        endcase
    endfunction

    // A gain within about plus or minus two, so that the step is often
    // below its clamp and the accumulator moves through its whole range.
    function automatic logic [15:0] tame_gain();
        int g;
        g = int'($urandom_range(0, 1023)) - 512;
        return g[15:0];
    endfunction

    // ------------------------------------------------------------------------
    // Register port
    // ------------------------------------------------------------------------
    task automatic reg_write(input logic [2:0] idx, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        // Only the low half is a register; writes past the map are dropped.
        if (idx <= REG_STEP_LIMIT) reg_shadow[idx] = data[15:0];
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic reg_check(input t_reg_idx idx);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {idx, 2'b00};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        if (prdata[15:0] !== reg_shadow[idx]) begin
            $display("%0t: register %s readback mismatch, expected %h, got %h",
                     $time, idx.name(), reg_shadow[idx], prdata[15:0]);
            err_cnt++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    // Waits until every owed word is back, then reloads and reads back all five
    // registers. The upper data bits carry noise that the block must drop,
    // and the unused addresses get a write each that must change nothing.
    task automatic load_settings(input logic [15:0] kp, input logic [15:0] ki,
                                 input logic [15:0] kd, input logic [15:0] il,
                                 input logic [15:0] sl);
        push <= 1'b0;
        while (drive_q.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 1) @(posedge i_clk);
        reg_write(REG_PROP_GAIN,   {16'($urandom), kp});
        reg_write(REG_INTEG_GAIN,  {16'($urandom), ki});
        reg_write(REG_DERIV_GAIN,  {16'($urandom), kd});
        reg_write(REG_INTEG_LIMIT, {16'($urandom), il});
        reg_write(REG_STEP_LIMIT,  {16'($urandom), sl});
        for (int k = REG_STEP_LIMIT + 1; k < 8; k++) reg_write(3'(k), $urandom);
        for (int k = 0; k <= REG_STEP_LIMIT; k++) reg_check(t_reg_idx'(k));
    endtask

    // ------------------------------------------------------------------------
    // Sample side
    // ------------------------------------------------------------------------
    // Offers one word and returns at the edge that accepts it. push is left
    // high, so back-to-back words need no extra assignment in between.
    task automatic offer_sample(input logic [15:0] tgt, input logic [15:0] meas,
                                input logic typed, input logic [23:0] want);
        logic [23:0] model_out;
        while (!no_idle && $urandom_range(0, 99) < 32) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        push       <= 1'b1;
        i_target   <= tgt;
        i_measured <= meas;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        // The model always advances; a hand-typed value, where there is one,
        // stands as the expectation in its place.
        model_out = advance_pid(tgt, meas);
        drive_q.push_back(typed ? want : model_out);
    endtask

    initial begin : stimulus
        int          setpoint;
        int          pick;
        t_mode       mode;
        logic [15:0] kp;
        logic [15:0] ki;
        logic [15:0] kd;
        logic [15:0] il;
        logic [15:0] sl;
        logic [15:0] tgt;
        logic [15:0] meas;

        err_cnt   = 0;
        no_idle   = 1'b0;
        hold_req  = 1'b0;
        err_d1    = '0;
        err_d2    = '0;
        drive_acc = '0;
        foreach (reg_shadow[k]) reg_shadow[k] = '0;

        i_rst_n    <= 1'b0;
        push       <= 1'b0;
        i_target   <= '0;
        i_measured <= '0;
        psel       <= 1'b0;
        penable    <= 1'b0;
        pwrite     <= 1'b0;
        paddr      <= '0;
        pwdata     <= '0;

        // Directed part. The hand-typed rows are those whose result is plain:
        // zero while every gain is still at its reset value, the positive and
        // negative saturation levels when the gains and limits are at their
        // maximum, and a held output when the step limit is zero.
        plan = '{
            row_fix(16'h7FFF, 16'h8000, 24'h000000),
            row_fix(16'h8000, 16'h7FFF, 24'h000000),
            row_fix(16'h0000, 16'h0000, 24'h000000),
            // Zero integral limit with extreme integral and derivative gains.
            row_set(16'h0100, 16'h7FFF, 16'h8000, 16'h0000, 16'hFFFF),
            row_smp(16'sd100, 16'sd40),
            row_smp(-16'sd7, 16'sd300),
            row_smp(16'h7FFF, 16'h7FFF),
            row_smp(16'sd1, -16'sd1),
            // Largest gains and limits: the accumulator hits both rails.
            row_set(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'hFFFF, 16'hFFFF),
            row_smp(16'h7FFF, 16'h8000),
            row_smp(16'h7FFF, 16'h8000),
            row_fix(16'h7FFF, 16'h8000, 24'h7FFF00),
            row_fix(16'h7FFF, 16'h8000, 24'h7FFF00),
            row_fix(16'h8000, 16'h7FFF, 24'h800100),
            // Zero step limit: the output stays at the negative rail.
            row_set(16'h1234, 16'h8000, 16'h7FFF, 16'h00FF, 16'h0000),
            row_fix(16'sd5000, -16'sd20000, 24'h800100),
            row_fix(16'h8000, 16'h7FFF, 24'h800100),
            // Most negative gains with unit limits.
            row_set(16'h8000, 16'h8000, 16'h8000, 16'h0001, 16'h0001),
            row_smp(16'h0000, 16'h0000),
            row_smp(16'h7FFF, 16'h8000),
            row_smp(16'h8000, 16'h7FFF),
            row_smp(16'hFFFF, 16'h0000),
            // Fractional gains, so the fraction bits of the output matter.
            row_set(16'h0080, 16'h0040, 16'hFFC0, 16'h0100, 16'h0040),
            row_smp(16'sd1000, 16'sd990),
            row_smp(16'sd1003, 16'sd990),
            row_smp(-16'sd2, 16'sd7),
            row_smp(16'sd123, -16'sd456)
        };

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (plan[n]) begin
            if (plan[n].kind == ROW_SETTINGS) begin
                load_settings(plan[n].w0, plan[n].w1, plan[n].w2, plan[n].w3, plan[n].w4);
            end else begin
                offer_sample(plan[n].w0, plan[n].w1, plan[n].typed, plan[n].want);
            end
        end

        // Random part: each phase loads a fresh set of registers and then
        // streams samples. Most samples track a slowly moving setpoint with a
        // small error, which keeps the loop away from the rails; the rest are
        // corner values and fully random words.
        setpoint = 0;
        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            mode = t_mode'(phase % 4);
            case (mode)
                MODE_TAME: begin
                    kp = tame_gain();
                    ki = tame_gain();
                    kd = tame_gain();
                    il = 16'($urandom_range(0, 3000));
                    sl = 16'($urandom_range(1, 3000));
                end
                MODE_WILD: begin
                    kp = 16'($urandom);
                    ki = 16'($urandom);
                    kd = 16'($urandom);
                    il = 16'($urandom);
                    sl = 16'($urandom);
                end
                MODE_CORNER: begin
                    kp = corner_word();
                    ki = corner_word();
                    kd = corner_word();
                    il = corner_word();
                    sl = corner_word();
                end
                default: begin
                    kp = tame_gain();
                    ki = tame_gain();
                    kd = tame_gain();
                    il = corner_word();
                    sl = corner_word();
                end
            endcase
            load_settings(kp, ki, kd, il, sl);

            // Phase 3 starts with the long receiver hold; phase 5 runs with
            // no idle cycles on either side.
            if (phase == 3) hold_req = 1'b1;
            no_idle = (phase == 5);

            for (int n = 0; n < PHASE_ITEMS; n++) begin
                pick = $urandom_range(0, 99);
                if (pick < 15) begin
                    tgt  = 16'($urandom);
                    meas = 16'($urandom);
                end else if (pick < 25) begin
                    tgt  = corner_word();
                    meas = corner_word();
                end else begin
                    if ($urandom_range(0, 99) < 5) setpoint = $signed(16'($urandom));
                    tgt  = sat16(setpoint);
                    meas = sat16(setpoint + int'($urandom_range(0, 600)) - 300);
                end
                offer_sample(tgt, meas, 1'b0, '0);
            end
        end
        no_idle = 1'b0;
        push <= 1'b0;

        // Let every owed word come back, then keep watching for any word
        // that the block should not have produced.
        while (drive_q.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 8) @(posedge i_clk);

        if (err_cnt == 0) begin
            $display("tb_incremental_pid_saturating_unit: done, clean");
        end else begin
            $display("tb_incremental_pid_saturating_unit: done, errors");
        end
        $finish;
    end

    // ------------------------------------------------------------------------
    // Result side: pops at random and checks each word against the oldest
    // expectation. Outputs are read right after the edge, before the block's
    // own updates of that edge land, so they hold the values the edge saw.
    // ------------------------------------------------------------------------
    initial begin : result_side
        int          hold_left;
        logic [23:0] want;
        hold_left = 0;
        hold_done = 1'b0;
        pop <= 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(posedge i_clk);
            if (pop && !empty) begin
                if (drive_q.size() == 0) begin
                    $display("%0t: unexpected control_out word, expected none, got %0d",
                             $time, o_control_out);
                    err_cnt++;
                end else begin
                    want = drive_q.pop_front();
                    if (o_control_out !== want) begin
                        $display("%0t: control_out mismatch, expected %0d, got %0d",
                                 $time, $signed(want), o_control_out);
                        err_cnt++;
                    end
                end
            end
            if (hold_req && !hold_done) begin
                hold_left = HOLD_CYCLES;
                hold_done = 1'b1;
            end
            if (hold_left > 0) begin
                hold_left--;
                pop <= 1'b0;
            end else begin
                pop <= no_idle || ($urandom_range(0, 99) >= 32);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog: ends the run when no word moves on either side for too long.
    // ------------------------------------------------------------------------
    initial begin : watchdog
        int quiet;
        quiet = 0;
        wait (i_rst_n === 1'b1);
        while (quiet < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((push && !full) || (pop && !empty)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("%0t: no word moved for %0d cycles", $time, STALL_LIMIT);
        $display("tb_incremental_pid_saturating_unit: done, errors");
        $finish;
    end

endmodule

FILE: sim.f
rtl/ips_pkg.sv
rtl/ips_queue.sv
rtl/ips_front.sv
rtl/ips_back.sv
rtl/incremental_pid_saturating_unit.sv
verif/tb_incremental_pid_saturating_unit.sv
